// ----- sv/pdpc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the PD drive position controller.
// No dependencies; imported by every module of the block.
package pdpc_pkg;

	// Port field widths
	localparam int ANG_W      = 32;
	localparam int SPD_W      = 24;
	localparam int TGT_W      = 32;
	localparam int LIM_W      = 16;
	localparam int GAIN_W     = 16;
	localparam int TRIM_W     = 16;
	localparam int TPD_W      = 24;
	localparam int DRV_OUT_W  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Internal datapath widths
	localparam int ANG_SUM_W  = ANG_W + 1;
	localparam int SPD_SUM_W  = SPD_W + 1;
	localparam int FRAC_SHIFT = 17;
	localparam int POS_W      = ANG_SUM_W + TPD_W - FRAC_SHIFT;
	localparam int VEL_W      = SPD_SUM_W + TPD_W + 1 - FRAC_SHIFT;
	localparam int ERR_W      = POS_W + 1;
	localparam int ERR_LO_W   = 24;
	localparam int ERR_HI_W   = ERR_W - ERR_LO_W;
	localparam int KPE_W      = GAIN_W + ERR_W;
	localparam int DGV_W      = GAIN_W + VEL_W;
	localparam int DRV_W      = KPE_W + 1;
	localparam int LIM_SHIFT  = 14;
	localparam int LIM_FULL_W = LIM_W + LIM_SHIFT;
	localparam int DRVC_W     = LIM_FULL_W + 1;
	localparam int TRP_W      = TRIM_W + LIM_FULL_W;
	localparam int SUM_W      = 34;
	localparam int TABS_W     = TGT_W;
	localparam int TEPS_W     = TGT_W + 1;

	// Shared multiplier
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 26;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Trim divide by 25600 = (x >> 10) / 25, four quotient bits per cycle
	localparam int DIV_SHIFT  = 10;
	localparam int DIV_W      = TRP_W - DIV_SHIFT;
	localparam int DIV_CONST  = 25;
	localparam int DIV_REM_W  = 5;
	localparam int DIV_RADIX  = 4;
	localparam int DIV_STEPS  = DIV_W / DIV_RADIX;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	// Percent (22 fraction bits) to millivolts: times 120, drop 22 bits
	localparam int MV_SHIFT = 22;

	// Settle detection, Q16.16
	localparam int NEAR_EPS     = 655;
	localparam int SLOW_VEL     = 4260;
	localparam int CLOSE_MARGIN = 13107;
	localparam int HOLD_VEL     = 196608;
	localparam int SETTLE_LIMIT = 10;
	localparam int CNT_W        = 4;

	// Register reset values
	localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd14720;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd194;

	// Action codes
	localparam logic ACT_START  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET = 3'd0,
		CFG_LIMIT  = 3'd1,
		CFG_PGAIN  = 3'd2,
		CFG_DGAIN  = 3'd3,
		CFG_RTRIM  = 3'd4,
		CFG_LTRIM  = 3'd5,
		CFG_TPD    = 3'd6
	} cfg_idx_t;

	// Operand selection of the shared multiplier
	typedef enum logic [2:0] {
		MUL_POS = 3'd0,
		MUL_VEL = 3'd1,
		MUL_KLO = 3'd2,
		MUL_KHI = 3'd3,
		MUL_DGV = 3'd4,
		MUL_TRR = 3'd5,
		MUL_TRL = 3'd6
	} mul_op_t;

	// What the output register is loaded with
	typedef enum logic [1:0] {
		OUT_ZERO  = 2'd0,
		OUT_DONE  = 2'd1,
		OUT_DRIVE = 2'd2
	} out_kind_t;

	// Controller to datapath
	typedef struct packed {
		logic      capture;
		mul_op_t   mul_op;
		logic      cap_err;
		logic      cap_vel;
		logic      cap_klo;
		logic      cap_kpe;
		logic      cap_drive;
		logic      clamp;
		logic      cap_trr;
		logic      div_load;
		logic      div_step;
		logic      cap_sum;
		logic      out_load;
		out_kind_t out_kind;
	} pdpc_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic near;
		logic slow;
	} pdpc_sts_t;

endpackage

// ----- sv/pdpc_div.sv -----
`timescale 1ns / 1ps
// One trim divider lane: signed product / 25600, truncated toward zero.
// Depends on pdpc_pkg.
module pdpc_div (
	input  logic                                  clk,
	input  logic                                  load,
	input  logic                                  step,
	input  logic signed [pdpc_pkg::TRP_W-1:0]     prod,
	output logic signed [pdpc_pkg::DIV_W:0]       quot
);
	import pdpc_pkg::*;

	logic [DIV_W-1:0]     dq_q;
	logic [DIV_REM_W-1:0] rem_q;
	logic                 neg_q;
	logic [TRP_W-1:0]     mag;
	logic [DIV_W-1:0]     dq_d;
	logic [DIV_REM_W-1:0] rem_d;

	assign mag = prod[TRP_W-1] ? TRP_W'(-prod) : TRP_W'(prod);

	// Restoring divide by 25, DIV_RADIX quotient bits per step
	always_comb begin
		logic [DIV_REM_W:0] r6;
		dq_d  = dq_q;
		rem_d = rem_q;
		for (int i = 0; i < DIV_RADIX; i++) begin
			r6 = {rem_d, dq_d[DIV_W-1]};
			if (r6 >= (DIV_REM_W+1)'(DIV_CONST)) begin
				dq_d  = {dq_d[DIV_W-2:0], 1'b1};
				rem_d = DIV_REM_W'(r6 - (DIV_REM_W+1)'(DIV_CONST));
			end else begin
				dq_d  = {dq_d[DIV_W-2:0], 1'b0};
				rem_d = r6[DIV_REM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dq_q  <= mag[TRP_W-1:DIV_SHIFT];
			rem_q <= '0;
			neg_q <= prod[TRP_W-1];
		end else if (step) begin
			dq_q  <= dq_d;
			rem_q <= rem_d;
		end
	end

	// Restore the sign of the dividend
	assign quot = neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});

endmodule

// ----- sv/pdpc_dpath.sv -----
`timescale 1ns / 1ps
// Datapath: registers, shared multiplier, settle compares, trim dividers, result register.
// Depends on pdpc_pkg and pdpc_div.
module pdpc_dpath (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  pdpc_pkg::pdpc_cmd_t                      cmd,
	output pdpc_pkg::pdpc_sts_t                      sts,
	input  logic                                     cfg_wr_en,
	input  logic [pdpc_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [pdpc_pkg::CFG_DATA_W-1:0]          cfg_data,
	input  logic signed [pdpc_pkg::ANG_W-1:0]        left_angle,
	input  logic signed [pdpc_pkg::ANG_W-1:0]        right_angle,
	input  logic signed [pdpc_pkg::SPD_W-1:0]        left_speed,
	input  logic signed [pdpc_pkg::SPD_W-1:0]        right_speed,
	output logic signed [pdpc_pkg::DRV_OUT_W-1:0]    right_drive,
	output logic signed [pdpc_pkg::DRV_OUT_W-1:0]    left_drive,
	output logic                                     done_res,
	output logic                                     brake
);
	import pdpc_pkg::*;

	localparam int MVX_W = SUM_W + 7;
	localparam int MVY_W = MVX_W - MV_SHIFT;

	// Configuration registers
	logic signed [TGT_W-1:0]  target_q;
	logic [LIM_W-1:0]         limit_q;
	logic [GAIN_W-1:0]        pgain_q;
	logic [GAIN_W-1:0]        dgain_q;
	logic signed [TRIM_W-1:0] rtrim_q;
	logic signed [TRIM_W-1:0] ltrim_q;
	logic [TPD_W-1:0]         tpd_q;

	// Work registers
	logic signed [ANG_SUM_W-1:0] ang_sum_q;
	logic signed [SPD_SUM_W-1:0] spd_sum_q;
	logic signed [MUL_A_W-1:0]   mul_a;
	logic signed [MUL_B_W-1:0]   mul_b;
	logic signed [MUL_P_W-1:0]   prod_q;
	logic signed [MUL_P_W-1:0]   prod_neg;
	logic signed [ERR_W-1:0]     err_q;
	logic signed [VEL_W-1:0]     vel_q;
	logic signed [KPE_W-1:0]     klo_q;
	logic signed [KPE_W-1:0]     kpe_q;
	logic [ERR_W-1:0]            e_abs_q;
	logic [VEL_W-1:0]            v_abs_q;
	logic [TABS_W-1:0]           t_abs_q;
	logic [TEPS_W-1:0]           t_eps_q;
	logic [TABS_W-1:0]           t_abs_c;
	logic signed [TEPS_W:0]      t_diff;
	logic signed [DRV_W-1:0]     drv_full_q;
	logic [KPE_W-1:0]            pe_abs_q;
	logic [DRV_W-1:0]            drv_abs;
	logic [LIM_FULL_W-1:0]       lim;
	logic signed [DRVC_W-1:0]    drive_q;
	logic                        pe_gt_q;
	logic [LIM_FULL_W-1:0]       pe_q;
	logic signed [TRP_W-1:0]     trr_q;
	logic signed [DIV_W:0]       quot_r;
	logic signed [DIV_W:0]       quot_l;
	logic signed [SUM_W-1:0]     trim_r;
	logic signed [SUM_W-1:0]     trim_l;
	logic signed [SUM_W-1:0]     pr_q;
	logic signed [SUM_W-1:0]     pl_q;

	// Percent with 22 fraction bits to saturated millivolts
	function automatic logic signed [DRV_OUT_W-1:0] to_mv(input logic signed [SUM_W-1:0] p);
		logic signed [MVX_W-1:0] xe;
		logic signed [MVX_W-1:0] x;
		logic signed [MVY_W-1:0] y;
		xe = MVX_W'(p);
		x  = (xe <<< 7) - (xe <<< 3);
		y  = x[MVX_W-1:MV_SHIFT];
		if (y > MVY_W'(32767))
			return DRV_OUT_W'(32767);
		else if (y < MVY_W'(-32768))
			return DRV_OUT_W'(-32768);
		else
			return y[DRV_OUT_W-1:0];
	endfunction

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			limit_q  <= '0;
			pgain_q  <= PROP_GAIN_RST;
			dgain_q  <= DERIV_GAIN_RST;
			rtrim_q  <= '0;
			ltrim_q  <= '0;
			tpd_q    <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TARGET: target_q <= cfg_data[TGT_W-1:0];
				CFG_LIMIT:  limit_q  <= cfg_data[LIM_W-1:0];
				CFG_PGAIN:  pgain_q  <= cfg_data[GAIN_W-1:0];
				CFG_DGAIN:  dgain_q  <= cfg_data[GAIN_W-1:0];
				CFG_RTRIM:  rtrim_q  <= cfg_data[TRIM_W-1:0];
				CFG_LTRIM:  ltrim_q  <= cfg_data[TRIM_W-1:0];
				CFG_TPD:    tpd_q    <= cfg_data[TPD_W-1:0];
				default: ;
			endcase
		end
	end

	// Multiplier operand selection
	always_comb begin
		unique case (cmd.mul_op)
			MUL_POS: begin
				mul_a = MUL_A_W'(ang_sum_q);
				mul_b = $signed(MUL_B_W'(tpd_q));
			end
			MUL_VEL: begin
				mul_a = MUL_A_W'(spd_sum_q);
				mul_b = $signed(MUL_B_W'(tpd_q));
			end
			MUL_KLO: begin
				mul_a = $signed(MUL_A_W'(err_q[ERR_LO_W-1:0]));
				mul_b = $signed(MUL_B_W'(pgain_q));
			end
			MUL_KHI: begin
				mul_a = MUL_A_W'($signed(err_q[ERR_W-1:ERR_LO_W]));
				mul_b = $signed(MUL_B_W'(pgain_q));
			end
			MUL_DGV: begin
				mul_a = MUL_A_W'(vel_q);
				mul_b = $signed(MUL_B_W'(dgain_q));
			end
			MUL_TRR: begin
				mul_a = $signed(MUL_A_W'(pe_q));
				mul_b = MUL_B_W'(rtrim_q);
			end
			MUL_TRL: begin
				mul_a = $signed(MUL_A_W'(pe_q));
				mul_b = MUL_B_W'(ltrim_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_neg = -prod_q;
	assign t_abs_c  = target_q[TGT_W-1] ? TABS_W'(-target_q) : TABS_W'(target_q);
	assign t_diff   = $signed({2'b00, t_abs_c}) - (TEPS_W+1)'(NEAR_EPS);
	assign drv_abs  = drv_full_q[DRV_W-1] ? DRV_W'(-drv_full_q) : DRV_W'(drv_full_q);
	assign lim      = {limit_q, {LIM_SHIFT{1'b0}}};

	// Trim contribution: full trim above the limit, else scaled by |kp*error|/100
	assign trim_r = pe_gt_q ? SUM_W'($signed({rtrim_q, {LIM_SHIFT{1'b0}}})) : SUM_W'(quot_r);
	assign trim_l = pe_gt_q ? SUM_W'($signed({ltrim_q, {LIM_SHIFT{1'b0}}})) : SUM_W'(quot_l);

	// Sequenced datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.capture) begin
			ang_sum_q <= ANG_SUM_W'(left_angle) + ANG_SUM_W'(right_angle);
			spd_sum_q <= SPD_SUM_W'(left_speed) + SPD_SUM_W'(right_speed);
		end
		// position = floor(tpd*angles / 2^17), error against the live target
		if (cmd.cap_err)
			err_q <= ERR_W'(target_q) - ERR_W'($signed(prod_q[FRAC_SHIFT+POS_W-1:FRAC_SHIFT]));
		if (cmd.cap_vel)
			vel_q <= prod_neg[FRAC_SHIFT+VEL_W-1:FRAC_SHIFT];
		if (cmd.cap_klo)
			klo_q <= prod_q[KPE_W-1:0];
		// Magnitudes for the settle compares, ready for the evaluate cycle
		if (cmd.cap_kpe) begin
			kpe_q   <= klo_q + $signed({prod_q[KPE_W-ERR_LO_W-1:0], {ERR_LO_W{1'b0}}});
			e_abs_q <= err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
			v_abs_q <= vel_q[VEL_W-1] ? VEL_W'(-vel_q) : VEL_W'(vel_q);
			t_abs_q <= t_abs_c;
			t_eps_q <= t_diff[TEPS_W] ? TEPS_W'(-t_diff) : t_diff[TEPS_W-1:0];
		end
		if (cmd.cap_drive) begin
			drv_full_q <= DRV_W'(kpe_q) + DRV_W'($signed(prod_q[DGV_W-1:0]));
			pe_abs_q   <= kpe_q[KPE_W-1] ? KPE_W'(-kpe_q) : KPE_W'(kpe_q);
		end
		// Clamp to the limit with the sign of the error
		if (cmd.clamp) begin
			if (drv_abs > DRV_W'(lim)) begin
				if (err_q > 0)
					drive_q <= $signed({1'b0, lim});
				else if (err_q < 0)
					drive_q <= -$signed({1'b0, lim});
				else
					drive_q <= '0;
			end else begin
				drive_q <= drv_full_q[DRVC_W-1:0];
			end
			pe_gt_q <= pe_abs_q > KPE_W'(lim);
			pe_q    <= pe_abs_q[LIM_FULL_W-1:0];
		end
		if (cmd.cap_trr)
			trr_q <= prod_q[TRP_W-1:0];
		if (cmd.cap_sum) begin
			pr_q <= SUM_W'(drive_q) + trim_r;
			pl_q <= SUM_W'(drive_q) + trim_l;
		end
		// Result register
		if (cmd.out_load) begin
			unique case (cmd.out_kind)
				OUT_DRIVE: begin
					right_drive <= to_mv(pr_q);
					left_drive  <= to_mv(pl_q);
					done_res    <= 1'b0;
					brake       <= 1'b0;
				end
				OUT_DONE: begin
					right_drive <= '0;
					left_drive  <= '0;
					done_res    <= 1'b1;
					brake       <= 1'b1;
				end
				default: begin
					right_drive <= '0;
					left_drive  <= '0;
					done_res    <= 1'b0;
					brake       <= 1'b0;
				end
			endcase
		end
	end

	// Trim dividers, right and left in parallel
	pdpc_div u_div_r (
		.clk  (clk),
		.load (cmd.div_load),
		.step (cmd.div_step),
		.prod (trr_q),
		.quot (quot_r)
	);

	pdpc_div u_div_l (
		.clk  (clk),
		.load (cmd.div_load),
		.step (cmd.div_step),
		.prod (prod_q[TRP_W-1:0]),
		.quot (quot_l)
	);

	// Settle status, valid while the controller evaluates
	assign sts.near = (e_abs_q < ERR_W'(t_eps_q)) ||
		((v_abs_q < VEL_W'(SLOW_VEL)) &&
		 (({1'b0, e_abs_q} + (ERR_W+1)'(CLOSE_MARGIN)) < (ERR_W+1)'(t_abs_q)));
	assign sts.slow = v_abs_q < VEL_W'(HOLD_VEL);

endmodule

// ----- sv/pdpc_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: input/output handshakes, move state, settle counter, operation sequencer.
// Depends on pdpc_pkg.
module pdpc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 action,
	output logic                 out_valid,
	input  logic                 out_stall,
	output pdpc_pkg::pdpc_cmd_t  cmd,
	input  pdpc_pkg::pdpc_sts_t  sts
);
	import pdpc_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_POS   = 14'b00000000000010,
		S_VEL   = 14'b00000000000100,
		S_KLO   = 14'b00000000001000,
		S_KHI   = 14'b00000000010000,
		S_DGV   = 14'b00000000100000,
		S_EVAL  = 14'b00000001000000,
		S_CLAMP = 14'b00000010000000,
		S_TRR   = 14'b00000100000000,
		S_TRL   = 14'b00001000000000,
		S_DLOAD = 14'b00010000000000,
		S_DIV   = 14'b00100000000000,
		S_SUM   = 14'b01000000000000,
		S_OUT   = 14'b10000000000000
	} state_t;

	state_t               state_q;
	state_t               state_d;
	logic                 running_q;
	logic [CNT_W-1:0]     settle_cnt_q;
	logic [CNT_W-1:0]     settle_cnt_d;
	logic                 settle_end;
	out_kind_t            kind_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;
	logic                 out_free;

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Settle counter: counts slow samples near target, clears on a fast one near target
	always_comb begin
		settle_cnt_d = settle_cnt_q;
		if (sts.near) begin
			if (sts.slow)
				settle_cnt_d = (settle_cnt_q == {CNT_W{1'b1}}) ? settle_cnt_q
					: settle_cnt_q + CNT_W'(1);
			else
				settle_cnt_d = '0;
		end
	end
	assign settle_end = sts.near && (settle_cnt_d > CNT_W'(SETTLE_LIMIT));

	// Sequencer
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.mul_op   = MUL_POS;
		cmd.out_kind = kind_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) begin
					if (action == ACT_SAMPLE && running_q)
						state_d = S_POS;
					else
						state_d = S_OUT;
				end
			end
			S_POS: state_d = S_VEL;
			S_VEL: begin
				cmd.mul_op  = MUL_VEL;
				cmd.cap_err = 1'b1;
				state_d     = S_KLO;
			end
			S_KLO: begin
				cmd.mul_op  = MUL_KLO;
				cmd.cap_vel = 1'b1;
				state_d     = S_KHI;
			end
			S_KHI: begin
				cmd.mul_op  = MUL_KHI;
				cmd.cap_klo = 1'b1;
				state_d     = S_DGV;
			end
			S_DGV: begin
				cmd.mul_op  = MUL_DGV;
				cmd.cap_kpe = 1'b1;
				state_d     = S_EVAL;
			end
			S_EVAL: begin
				cmd.cap_drive = 1'b1;
				state_d       = settle_end ? S_OUT : S_CLAMP;
			end
			S_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d   = S_TRR;
			end
			S_TRR: begin
				cmd.mul_op = MUL_TRR;
				state_d    = S_TRL;
			end
			S_TRL: begin
				cmd.mul_op  = MUL_TRL;
				cmd.cap_trr = 1'b1;
				state_d     = S_DLOAD;
			end
			S_DLOAD: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1))
					state_d = S_SUM;
			end
			S_SUM: begin
				cmd.cap_sum = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			running_q    <= 1'b0;
			settle_cnt_q <= '0;
			kind_q       <= OUT_ZERO;
			div_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && in_valid) begin
				if (action == ACT_START) begin
					running_q    <= 1'b1;
					settle_cnt_q <= '0;
					kind_q       <= OUT_ZERO;
				end else begin
					kind_q <= running_q ? OUT_DRIVE : OUT_ZERO;
				end
			end
			if (state_q == S_EVAL) begin
				settle_cnt_q <= settle_cnt_d;
				if (settle_end) begin
					running_q <= 1'b0;
					kind_q    <= OUT_DONE;
				end
			end
			if (state_q == S_DLOAD)
				div_cnt_q <= '0;
			else if (state_q == S_DIV)
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			// Output transfer
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	a_running_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> settle_cnt_q <= CNT_W'(SETTLE_LIMIT))
		else $error("settle count above limit while move armed");

	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && kind_q == OUT_DONE) |-> !running_q)
		else $error("done result while move still armed");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> div_cnt_q < DIV_CNT_W'(DIV_STEPS))
		else $error("divide step count overrun");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result presented outside output state");

	a_drive_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POS) |-> (running_q && kind_q == OUT_DRIVE))
		else $error("control sample processed while idle");

endmodule

// ----- sv/pd_drive_position_controller.sv -----
`timescale 1ns / 1ps
// Sequence: a start item, or a sample while no move is armed, goes straight to the output
// state; a sample that ends the move passes the multiply and evaluate states first; any other
// sample takes seven passes through the shared 34x26 multiplier and a nine-step divide-by-25
// loop (four quotient bits per step) for the trims. in_stall holds off new items meanwhile.
// Reset (arst_n, async): disarms the move, clears the settle count and the result register
// valid, and returns all configuration registers to their reset values; no clearing pass.
module pd_drive_position_controller (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic                                     action,
	input  logic signed [pdpc_pkg::ANG_W-1:0]        left_angle,
	input  logic signed [pdpc_pkg::ANG_W-1:0]        right_angle,
	input  logic signed [pdpc_pkg::SPD_W-1:0]        left_speed,
	input  logic signed [pdpc_pkg::SPD_W-1:0]        right_speed,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic signed [pdpc_pkg::DRV_OUT_W-1:0]    right_drive,
	output logic signed [pdpc_pkg::DRV_OUT_W-1:0]    left_drive,
	output logic                                     done_res,
	output logic                                     brake,
	input  logic                                     cfg_wr_en,
	input  logic [pdpc_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [pdpc_pkg::CFG_DATA_W-1:0]          cfg_data
);
	import pdpc_pkg::*;

	pdpc_cmd_t cmd;
	pdpc_sts_t sts;

	// Sequencer and handshakes
	pdpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Arithmetic and result register
	pdpc_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.left_angle  (left_angle),
		.right_angle (right_angle),
		.left_speed  (left_speed),
		.right_speed (right_speed),
		.right_drive (right_drive),
		.left_drive  (left_drive),
		.done_res    (done_res),
		.brake       (brake)
	);

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for pd_drive_position_controller: directed and shaped random
// moves on the valid/stall ports, results scored against an in-bench PD loop predictor.
// Depends on pdpc_pkg and the block's RTL only.
module tb_top;
	import pdpc_pkg::*;

	localparam int     PHASES          = 10;
	localparam int     PHASE_ITEMS     = 118;
	localparam int     IDLE_CYCLES     = 30;
	localparam int     WATCHDOG_LIMIT  = 2000;
	localparam int     MV_PER_PCT      = 120;
	localparam int     TRIM_DIV        = 25600;
	localparam longint ANG_SPAN        = (64'sd1 <<< 32) - 2;
	localparam longint SPD_SPAN        = (64'sd1 <<< 24) - 2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	// One input transfer
	typedef struct packed {
		logic                    act;
		logic signed [ANG_W-1:0] la;
		logic signed [ANG_W-1:0] ra;
		logic signed [SPD_W-1:0] ls;
		logic signed [SPD_W-1:0] rs;
	} sample_t;

	// One result transfer
	typedef struct packed {
		logic signed [DRV_OUT_W-1:0] right_mv;
		logic signed [DRV_OUT_W-1:0] left_mv;
		logic                        done_flag;
		logic                        brake_flag;
	} drive_res_t;

	// Predicts the drive for each accepted sample and scores the results in order
	class drive_scoreboard;
		logic signed [TGT_W-1:0]  target;
		logic [LIM_W-1:0]         limit;
		logic [GAIN_W-1:0]        kp;
		logic [GAIN_W-1:0]        kd;
		logic signed [TRIM_W-1:0] trim_r;
		logic signed [TRIM_W-1:0] trim_l;
		logic [TPD_W-1:0]         tpd;
		bit                       armed;
		logic [CNT_W-1:0]         settle_cnt;
		drive_res_t               expected_drive[$];
		int                       mismatches;

		function new();
			target     = '0;
			limit      = '0;
			kp         = PROP_GAIN_RST;
			kd         = DERIV_GAIN_RST;
			trim_r     = '0;
			trim_l     = '0;
			tpd        = '0;
			armed      = 1'b0;
			settle_cnt = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_TARGET: target = data[TGT_W-1:0];
				CFG_LIMIT:  limit  = data[LIM_W-1:0];
				CFG_PGAIN:  kp     = data[GAIN_W-1:0];
				CFG_DGAIN:  kd     = data[GAIN_W-1:0];
				CFG_RTRIM:  trim_r = data[TRIM_W-1:0];
				CFG_LTRIM:  trim_l = data[TRIM_W-1:0];
				CFG_TPD:    tpd    = data[TPD_W-1:0];
				default: ;
			endcase
		endfunction

		static function longint mag(longint v);
			return (v < 0) ? -v : v;
		endfunction

		// Full trim once the P term is past the limit, else scaled by |P|/100
		static function longint trim_share(longint trim, longint pe, longint lim);
			if (pe > lim)
				return trim <<< LIM_SHIFT;
			return (trim * pe) / TRIM_DIV;
		endfunction

		// Percent with 22 fraction bits to saturated millivolts
		static function logic signed [DRV_OUT_W-1:0] to_millivolts(longint p);
			longint m;
			m = (p * MV_PER_PCT) >>> MV_SHIFT;
			if (m > 32767)
				m = 32767;
			else if (m < -32768)
				m = -32768;
			return m[DRV_OUT_W-1:0];
		endfunction

		function drive_res_t predict_drive(sample_t s);
			drive_res_t res;
			longint     scale, pos, vel, err, tgt, t, e, v, kpe, drv, lim, pe, sgn;
			bit         near_tgt;
			res = '0;
			if (s.act == ACT_START) begin
				armed      = 1'b1;
				settle_cnt = '0;
				return res;
			end
			if (!armed)
				return res;

			scale = longint'(tpd);
			pos   = (scale * (longint'($signed(s.la)) + longint'($signed(s.ra)))) >>> FRAC_SHIFT;
			vel   = (-(scale * (longint'($signed(s.ls)) + longint'($signed(s.rs)))))
				>>> FRAC_SHIFT;
			tgt   = longint'($signed(target));
			err   = tgt - pos;

			// settle detection
			t = mag(tgt);
			e = mag(err);
			v = mag(vel);
			near_tgt = (e < mag(t - NEAR_EPS)) || (v < SLOW_VEL && e + CLOSE_MARGIN < t);
			if (near_tgt) begin
				if (v < HOLD_VEL) begin
					if (settle_cnt < 4'd15)
						settle_cnt++;
				end else
					settle_cnt = '0;
				if (settle_cnt > SETTLE_LIMIT) begin
					armed          = 1'b0;
					res.done_flag  = 1'b1;
					res.brake_flag = 1'b1;
					return res;
				end
			end

			// PD drive, clamped by error sign, plus per-side trim
			kpe = longint'(kp) * err;
			drv = kpe + longint'(kd) * vel;
			lim = longint'(limit) <<< LIM_SHIFT;
			sgn = (err > 0) ? 1 : ((err < 0) ? -1 : 0);
			if (mag(drv) > lim)
				drv = lim * sgn;
			pe = mag(kpe);
			res.right_mv = to_millivolts(drv + trim_share(longint'($signed(trim_r)), pe, lim));
			res.left_mv  = to_millivolts(drv + trim_share(longint'($signed(trim_l)), pe, lim));
			return res;
		endfunction

		function void note_item(sample_t s);
			expected_drive.push_back(predict_drive(s));
		endfunction

		function void check_result(drive_res_t got);
			drive_res_t want;
			if (expected_drive.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: R=%0d L=%0d done=%0b brake=%0b",
						got.right_mv, got.left_mv, got.done_flag, got.brake_flag);
			end else begin
				want = expected_drive.pop_front();
				if (want.right_mv !== got.right_mv || want.left_mv !== got.left_mv ||
					want.done_flag !== got.done_flag || want.brake_flag !== got.brake_flag) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected R=%0d L=%0d done=%0b brake=%0b, %s",
							want.right_mv, want.left_mv, want.done_flag, want.brake_flag,
							$sformatf("got R=%0d L=%0d done=%0b brake=%0b",
								got.right_mv, got.left_mv, got.done_flag, got.brake_flag));
				end
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n      = 1'b0;
	logic                        in_valid    = 1'b0;
	logic                        in_stall;
	logic                        action      = ACT_SAMPLE;
	logic signed [ANG_W-1:0]     left_angle  = '0;
	logic signed [ANG_W-1:0]     right_angle = '0;
	logic signed [SPD_W-1:0]     left_speed  = '0;
	logic signed [SPD_W-1:0]     right_speed = '0;
	logic                        out_valid;
	logic                        out_stall   = 1'b0;
	logic signed [DRV_OUT_W-1:0] right_drive;
	logic signed [DRV_OUT_W-1:0] left_drive;
	logic                        done_res;
	logic                        brake;
	logic                        cfg_wr_en   = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index   = '0;
	logic [CFG_DATA_W-1:0]       cfg_data    = '0;

	drive_scoreboard sb = new();
	int              items_sent   = 0;
	int              gap_pct      = 0;
	bit              quiet        = 1'b0;
	int              stall_run    = 0;
	int              stuck_cycles = 0;

	pd_drive_position_controller u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.left_angle (left_angle),
		.right_angle(right_angle),
		.left_speed (left_speed),
		.right_speed(right_speed),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.right_drive(right_drive),
		.left_drive (left_drive),
		.done_res   (done_res),
		.brake      (brake),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls in bursts; none in the quiet tail of the run
	always @(posedge clk) begin
		if (stall_run > 1)
			stall_run <= stall_run - 1;
		else if (quiet) begin
			out_stall <= 1'b0;
			stall_run <= 0;
		end else if ($urandom_range(0, 2) == 0) begin
			out_stall <= 1'b1;
			stall_run <= $urandom_range(1, 16);
		end else begin
			out_stall <= 1'b0;
			stall_run <= $urandom_range(1, 40);
		end
	end

	// Transfer monitor: score results, note inputs, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(drive_res_t'{right_drive, left_drive, done_res, brake});
			if (in_valid && !in_stall)
				sb.note_item(sample_t'{action, left_angle, right_angle, left_speed, right_speed});
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	function automatic longint spread(int unsigned m);
		longint v;
		v = longint'($urandom_range(0, m));
		return ($urandom_range(0, 1) != 0) ? -v : v;
	endfunction

	function automatic sample_t noise_sample();
		sample_t s;
		s.act = ($urandom_range(0, 3) == 0) ? ACT_START : ACT_SAMPLE;
		s.la  = $urandom();
		s.ra  = $urandom();
		s.ls  = SPD_W'($urandom());
		s.rs  = SPD_W'($urandom());
		return s;
	endfunction

	// Sample whose encoders give the wanted position and velocity (Q16.16)
	function automatic sample_t shaped_sample(longint pos, longint vel);
		sample_t s;
		longint  scale, asum, ssum;
		s     = noise_sample();
		s.act = ACT_SAMPLE;
		scale = longint'(sb.tpd);
		if (scale != 0) begin
			asum = (pos <<< FRAC_SHIFT) / scale;
			if (asum > ANG_SPAN)
				asum = ANG_SPAN;
			else if (asum < -ANG_SPAN)
				asum = -ANG_SPAN;
			s.la = ANG_W'(asum >>> 1);
			s.ra = ANG_W'(asum - (asum >>> 1));
			ssum = -((vel <<< FRAC_SHIFT) / scale);
			if (ssum > SPD_SPAN)
				ssum = SPD_SPAN;
			else if (ssum < -SPD_SPAN)
				ssum = -SPD_SPAN;
			s.ls = SPD_W'(ssum >>> 1);
			s.rs = SPD_W'(ssum - (ssum >>> 1));
		end
		return s;
	endfunction

	// Offer one item, with an optional sender gap, and hold it until the transfer
	task automatic send_item(sample_t s);
		if (!quiet && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= s.act;
		left_angle  <= s.la;
		right_angle <= s.ra;
		left_speed  <= s.ls;
		right_speed <= s.rs;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// Let every outstanding result arrive, then a margin past the sample latency
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.expected_drive.size() != 0)
			@(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	// Full register set, plus a write to the unused index that must be ignored
	task automatic program_regs(logic [TGT_W-1:0] tgt, logic [LIM_W-1:0] lim,
		logic [GAIN_W-1:0] pg, logic [GAIN_W-1:0] dg, logic [TRIM_W-1:0] tr,
		logic [TRIM_W-1:0] tl, logic [TPD_W-1:0] scale);
		cfg_write(CFG_TARGET, CFG_DATA_W'(tgt));
		cfg_write(CFG_LIMIT, CFG_DATA_W'(lim));
		cfg_write(CFG_PGAIN, CFG_DATA_W'(pg));
		cfg_write(CFG_DGAIN, CFG_DATA_W'(dg));
		cfg_write(CFG_RTRIM, CFG_DATA_W'(tr));
		cfg_write(CFG_LTRIM, CFG_DATA_W'(tl));
		cfg_write(CFG_TPD, CFG_DATA_W'(scale));
		cfg_write(CFG_UNUSED, $urandom());
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		sample_t               s;
		longint                tgt, err, vel;
		int                    ph, phase_start, r;
		bit                    calm;
		logic [TGT_W-1:0]      v_tgt;
		logic [LIM_W-1:0]      v_lim;
		logic [GAIN_W-1:0]     v_kp, v_kd;
		logic [TRIM_W-1:0]     v_tr, v_tl;
		logic [TPD_W-1:0]      v_tpd;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a sample before any start gives a zero result
		s = '{ACT_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 24'h7F_FFFF, 24'h80_0000};
		send_item(s);
		wait_idle();

		// Unit scale: position is the angle sum, velocity the negated speed sum
		tgt = 5 <<< 16;
		program_regs(32'(tgt), 16'd25600, PROP_GAIN_RST, DERIV_GAIN_RST, 16'h0200, 16'hFD00,
			24'h02_0000);
		s = '{ACT_START, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h7F_FFFF, 24'h7F_FFFF};
		send_item(s);
		send_item(shaped_sample(0, 0));
		s = '{ACT_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h80_0000, 24'h80_0000};
		send_item(s);
		s = '{ACT_SAMPLE, 32'h8000_0000, 32'h8000_0000, 24'h7F_FFFF, 24'h7F_FFFF};
		send_item(s);
		// restart while armed
		s.act = ACT_START;
		send_item(s);
		// zero error at speed: drive from the derivative term alone, settle count cleared
		send_item(shaped_sample(tgt, 300000));
		// eleven slow samples near target end the move
		for (int k = 1; k <= 11; k++)
			send_item(shaped_sample(tgt - k * 1000, k * 300));
		send_item(shaped_sample(0, 0));
		s = '{ACT_START, 32'hAAAA_AAAA, 32'h5555_5555, 24'hAA_AAAA, 24'h55_5555};
		send_item(s);
		s = '{ACT_SAMPLE, 32'h5555_5555, 32'hAAAA_AAAA, 24'h55_5555, 24'hAA_AAAA};
		send_item(s);

		// Random phases, each with its own register set
		for (ph = 1; ph <= PHASES; ph++) begin
			wait_idle();
			quiet = (ph == PHASES);
			case ($urandom_range(0, 2))
				0:       gap_pct = 0;
				1:       gap_pct = 15;
				default: gap_pct = 40;
			endcase

			v_tgt = ($urandom_range(0, 3) == 0) ? 32'(spread(2000)) : 32'(spread(60 << 16));
			if (ph == 1)
				v_tgt = 32'h7FFF_FFFF;
			else if (ph == 2)
				v_tgt = 32'h8000_0000;
			else if (ph == 3)
				v_tgt = '0;
			v_lim = (ph == 2) ? 16'h0000 : (ph == 3) ? 16'hFFFF : 16'($urandom_range(256, 40000));
			v_kp  = (ph == 4) ? 16'h0000 : (ph == 5) ? 16'hFFFF : 16'($urandom_range(2000, 30000));
			v_kd  = (ph == 4) ? 16'hFFFF : (ph == 5) ? 16'h0000 : 16'($urandom_range(0, 2000));
			v_tr  = (ph == 6) ? 16'h8000 : (ph == 7) ? 16'h7FFF : 16'(spread(3000));
			v_tl  = (ph == 6) ? 16'h7FFF : (ph == 7) ? 16'h8000 : 16'(spread(3000));
			v_tpd = (ph == 8) ? 24'h00_0000 : (ph == 9) ? 24'hFF_FFFF :
				24'($urandom_range(1 << 16, 1 << 20));
			program_regs(v_tgt, v_lim, v_kp, v_kd, v_tr, v_tl, v_tpd);

			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 3) != 0) begin
					// a move: start, then samples closing in on the target
					s     = noise_sample();
					s.act = ACT_START;
					send_item(s);
					tgt  = longint'($signed(v_tgt));
					err  = tgt;
					calm = ($urandom_range(0, 2) != 0);
					repeat ($urandom_range(4, 24)) begin
						if ($urandom_range(0, 7) == 0)
							err = spread(32'hFFFF_FFFF);
						else
							err = (err * longint'($urandom_range(0, 6))) / 8 + spread(200);
						r   = $urandom_range(0, 9);
						vel = (r < 7) ? spread(4000) :
							(r < 9 || calm) ? spread(150000) : spread(1 << 22);
						send_item(shaped_sample(tgt - err, vel));
					end
				end else begin
					repeat ($urandom_range(1, 4))
						send_item(noise_sample());
				end
			end
		end

		wait_idle();
		if (sb.mismatches == 0 && sb.expected_drive.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
